FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every rising clock edge outside reset
`define CHI_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// Condition must never be true outside reset
`define CHI_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define CHI_ASSERT(name, clk, rst_n, prop)
`define CHI_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

FILE: hw/rtl/chi_pkg.sv
// ----------------------------------------------------------------------------
// chi_pkg
// Types, codes and elaboration-time sigmoid table helpers for the
// continuous Hopfield iteration core.
// ----------------------------------------------------------------------------
package chi_pkg;

	// Input item commands
	localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
	localparam logic [1:0] CMD_LOAD_BIAS   = 2'd1;
	localparam logic [1:0] CMD_LOAD_ACT    = 2'd2;
	localparam logic [1:0] CMD_RUN         = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_NEURON_COUNT    = 2'd0;
	localparam logic [1:0] CFG_ITERATION_COUNT = 2'd1;
	localparam logic [1:0] CFG_STEP_SIZE       = 2'd2;
	localparam logic [1:0] CFG_GAIN            = 2'd3;

	// Configuration reset values
	localparam logic [6:0]  RST_NEURON_COUNT    = 7'd16;
	localparam logic [15:0] RST_ITERATION_COUNT = 16'd1000;
	localparam logic [16:0] RST_STEP_SIZE       = 17'd655;
	localparam logic [30:0] RST_GAIN            = 31'd65536;

	// ln(2) in Q0.16
	localparam logic [15:0] LN2_Q16 = 16'd45426;

	typedef struct packed {
		logic [1:0]         command;
		logic [5:0]         row_index;
		logic [5:0]         col_index;
		logic signed [31:0] load_value;
	} in_t;

	typedef struct packed {
		logic [5:0]  neuron_index;
		logic [15:0] activation;
		logic        last;
	} out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic ld_weight;
		logic ld_bias;
		logic ld_act;
		logic log_init;
		logic log_sel_b;
		logic log_step;
		logic inv_mul1;
		logic inv_mul2;
		logic acc_clr;
		logic mac_rd;
		logic drive_en;
		logic smul_en;
		logic ssat_en;
		logic div_init;
		logic div_step;
		logic act_idx;
		logic act_wr;
		logic copy_wr;
		logic a_rd_row;
		logic out_load;
		logic out_last;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [6:0]  neuron_count;
		logic [15:0] iteration_count;
	} st_t;

	// Shift-subtract unsigned division, evaluated at elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sigmoid table entry idx for a table of 2^tb entries over [-8, 8)
	function automatic logic [15:0] sig_entry(input int idx, input int tb);
		logic signed [63:0] t;
		logic [63:0] s;
		logic [63:0] u;
		logic [63:0] term;
		logic [63:0] e;
		logic [63:0] q;
		logic [63:0] one;
		one  = 64'd1 << 20;
		t    = $signed(64'(idx) << (20 - tb)) - 64'sd524288;
		s    = (t < 0) ? 64'(-t) : 64'(t);
		u    = s << 1;
		term = one;
		e    = one;
		for (int k = 1; k <= 12; k++) begin
			term = udiv64((term * u) >> 20, 64'(k));
			e    = e + term;
		end
		for (int k = 0; k < 3; k++) begin
			e = (e * e) >> 20;
		end
		if (t >= 0) begin
			q = udiv64(e << 16, e + one);
		end else begin
			q = udiv64(one << 16, e + one);
		end
		if (q > 64'd65535) begin
			q = 64'd65535;
		end
		return q[15:0];
	endfunction

endpackage

FILE: hw/rtl/chi_ctrl.sv
// ----------------------------------------------------------------------------
// chi_ctrl
// Sequencer: decodes items, walks loads, Euler iterations and result output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chi_ctrl #(
	parameter int MAX_NEURONS = 64,
	localparam int IW  = $clog2(MAX_NEURONS),
	localparam int CW  = IW + 1,
	localparam int WAW = $clog2(MAX_NEURONS * MAX_NEURONS)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     in_command,
	output logic           out_valid,
	input  logic           out_ready,
	input  chi_pkg::st_t   st,
	output chi_pkg::cmd_t  cmd,
	output logic [IW-1:0]  row_idx,
	output logic [IW-1:0]  col_idx,
	output logic [WAW-1:0] w_raddr
);
	import chi_pkg::*;

	localparam int RUN_LIMIT = (MAX_NEURONS < 64) ? MAX_NEURONS : 64;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_LOG_INIT  = 5'd1;
	localparam logic [4:0] S_LOG_STEP  = 5'd2;
	localparam logic [4:0] S_INV_MUL1  = 5'd3;
	localparam logic [4:0] S_INV_MUL2  = 5'd4;
	localparam logic [4:0] S_ROW_START = 5'd5;
	localparam logic [4:0] S_MAC       = 5'd6;
	localparam logic [4:0] S_MAC_DRAIN = 5'd7;
	localparam logic [4:0] S_DRIVE     = 5'd8;
	localparam logic [4:0] S_STEP_MUL  = 5'd9;
	localparam logic [4:0] S_STEP_SAT  = 5'd10;
	localparam logic [4:0] S_DIV_INIT  = 5'd11;
	localparam logic [4:0] S_DIV_STEP  = 5'd12;
	localparam logic [4:0] S_ACT_IDX   = 5'd13;
	localparam logic [4:0] S_ACT_WR    = 5'd14;
	localparam logic [4:0] S_COPY_RD   = 5'd15;
	localparam logic [4:0] S_COPY_WR   = 5'd16;
	localparam logic [4:0] S_OUT_RD    = 5'd17;
	localparam logic [4:0] S_OUT_LD    = 5'd18;
	localparam logic [4:0] S_OUT_WAIT  = 5'd19;

	logic [4:0]     state_q;
	logic [CW-1:0]  i_q;
	logic [CW-1:0]  j_q;
	logic [WAW-1:0] wbase_q;
	logic [15:0]    iter_q;
	logic [4:0]     bcnt_q;
	logic           phase_q;

	logic [6:0]    n_lim;
	logic [CW-1:0] n_run;
	logic          in_fire;
	logic          i_last;
	logic          j_last;

	// Neurons in use, limited to the storage and the output index range
	assign n_lim   = (st.neuron_count > 7'(RUN_LIMIT)) ? 7'(RUN_LIMIT) : st.neuron_count;
	assign n_run   = CW'(n_lim);
	assign in_fire = in_valid && in_ready;
	assign i_last  = ((i_q + CW'(1)) == n_run);
	assign j_last  = ((j_q + CW'(1)) == n_run);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT_WAIT);
	assign row_idx   = i_q[IW-1:0];
	assign col_idx   = j_q[IW-1:0];
	assign w_raddr   = wbase_q + WAW'(j_q);

	// Decode datapath commands from the state
	always_comb begin
		cmd           = '0;
		cmd.ld_weight = in_fire && (in_command == CMD_LOAD_WEIGHT);
		cmd.ld_bias   = in_fire && (in_command == CMD_LOAD_BIAS);
		cmd.ld_act    = in_fire && (in_command == CMD_LOAD_ACT);
		cmd.log_init  = (state_q == S_LOG_INIT);
		cmd.log_sel_b = phase_q;
		cmd.log_step  = (state_q == S_LOG_STEP);
		cmd.inv_mul1  = (state_q == S_INV_MUL1);
		cmd.inv_mul2  = (state_q == S_INV_MUL2);
		cmd.acc_clr   = (state_q == S_ROW_START);
		cmd.mac_rd    = (state_q == S_MAC);
		cmd.drive_en  = (state_q == S_DRIVE);
		cmd.smul_en   = (state_q == S_STEP_MUL);
		cmd.ssat_en   = (state_q == S_STEP_SAT);
		cmd.div_init  = (state_q == S_DIV_INIT);
		cmd.div_step  = (state_q == S_DIV_STEP);
		cmd.act_idx   = (state_q == S_ACT_IDX);
		cmd.act_wr    = (state_q == S_ACT_WR);
		cmd.copy_wr   = (state_q == S_COPY_WR);
		cmd.a_rd_row  = (state_q == S_OUT_RD);
		cmd.out_load  = (state_q == S_OUT_LD);
		cmd.out_last  = i_last;
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			wbase_q <= '0;
			iter_q  <= '0;
			bcnt_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && in_command == CMD_LOAD_ACT) begin
						phase_q <= 1'b0;
						state_q <= S_LOG_INIT;
					end else if (in_fire && in_command == CMD_RUN) begin
						i_q     <= '0;
						wbase_q <= '0;
						iter_q  <= '0;
						if (n_run == '0) begin
							state_q <= S_IDLE;
						end else if (st.iteration_count == 16'd0) begin
							state_q <= S_OUT_RD;
						end else begin
							state_q <= S_ROW_START;
						end
					end
				end
				S_LOG_INIT: begin
					bcnt_q  <= '0;
					state_q <= S_LOG_STEP;
				end
				S_LOG_STEP: begin
					bcnt_q <= bcnt_q + 5'd1;
					if (bcnt_q == 5'd15) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= S_LOG_INIT;
						end else begin
							state_q <= S_INV_MUL1;
						end
					end
				end
				S_INV_MUL1: state_q <= S_INV_MUL2;
				S_INV_MUL2: state_q <= S_IDLE;
				S_ROW_START: begin
					j_q     <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					j_q <= j_q + CW'(1);
					if (j_last) begin
						bcnt_q  <= '0;
						state_q <= S_MAC_DRAIN;
					end
				end
				S_MAC_DRAIN: begin
					bcnt_q <= bcnt_q + 5'd1;
					if (bcnt_q == 5'd1) begin
						state_q <= S_DRIVE;
					end
				end
				S_DRIVE:    state_q <= S_STEP_MUL;
				S_STEP_MUL: state_q <= S_STEP_SAT;
				S_STEP_SAT: state_q <= S_DIV_INIT;
				S_DIV_INIT: begin
					bcnt_q  <= '0;
					state_q <= S_DIV_STEP;
				end
				S_DIV_STEP: begin
					bcnt_q <= bcnt_q + 5'd1;
					if (bcnt_q == 5'd19) begin
						state_q <= S_ACT_IDX;
					end
				end
				S_ACT_IDX: state_q <= S_ACT_WR;
				S_ACT_WR: begin
					if (i_last) begin
						i_q     <= '0;
						state_q <= S_COPY_RD;
					end else begin
						i_q     <= i_q + CW'(1);
						wbase_q <= wbase_q + WAW'(MAX_NEURONS);
						state_q <= S_ROW_START;
					end
				end
				S_COPY_RD: state_q <= S_COPY_WR;
				S_COPY_WR: begin
					if (i_last) begin
						i_q     <= '0;
						wbase_q <= '0;
						iter_q  <= iter_q + 16'd1;
						if ((iter_q + 16'd1) == st.iteration_count) begin
							state_q <= S_OUT_RD;
						end else begin
							state_q <= S_ROW_START;
						end
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_COPY_RD;
					end
				end
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: state_q <= S_OUT_WAIT;
				S_OUT_WAIT: begin
					if (out_ready) begin
						if (i_last) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CHI_ASSERT(a_act_load_starts_log, clk, arst_n, (in_fire && in_command == CMD_LOAD_ACT) |=> (state_q == S_LOG_INIT))
	`CHI_ASSERT(a_mac_col_in_range, clk, arst_n, (state_q == S_MAC) |-> (j_q < n_run))
	`CHI_ASSERT(a_last_ends_run, clk, arst_n, (out_valid && out_ready && i_last) |=> (state_q == S_IDLE))

endmodule

FILE: hw/rtl/chi_dpath.sv
// ----------------------------------------------------------------------------
// chi_dpath
// Datapath: configuration registers, stores, MAC pipeline, log2 unit,
// Euler update, serial divider and sigmoid table.
// ----------------------------------------------------------------------------
module chi_dpath #(
	parameter int MAX_NEURONS        = 64,
	parameter int SIGMOID_TABLE_BITS = 10,
	localparam int IW  = $clog2(MAX_NEURONS),
	localparam int WAW = $clog2(MAX_NEURONS * MAX_NEURONS)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [30:0]    cfg_data,
	input  chi_pkg::in_t   in_data,
	input  chi_pkg::cmd_t  cmd,
	input  logic [IW-1:0]  row_idx,
	input  logic [IW-1:0]  col_idx,
	input  logic [WAW-1:0] w_raddr,
	output chi_pkg::st_t   st,
	output chi_pkg::out_t  out_data
);
	import chi_pkg::*;

	localparam int TABLE_SIZE = 1 << SIGMOID_TABLE_BITS;
	localparam int WDEPTH     = MAX_NEURONS * MAX_NEURONS;

	// Configuration
	logic [6:0]  neuron_count_q;
	logic [15:0] iteration_q;
	logic [16:0] step_q;
	logic [30:0] gain_q;
	logic [30:0] geff;

	// Stores
	logic signed [31:0] w_mem [WDEPTH];
	logic signed [31:0] b_mem [MAX_NEURONS];
	logic signed [31:0] p_mem [MAX_NEURONS];
	logic [15:0]        a_mem [MAX_NEURONS];
	logic [15:0]        f_mem [MAX_NEURONS];
	logic [15:0]        sig_rom [TABLE_SIZE];

	logic signed [31:0] w_rd_s1;
	logic signed [31:0] b_rd_q;
	logic signed [31:0] p_rd_q;
	logic [15:0]        a_rd_q;
	logic [15:0]        f_rd_q;
	logic [IW-1:0]      a_raddr;

	// Load decode
	logic          row_ok;
	logic          col_ok;
	logic [15:0]   x_sat;
	logic [15:0]   x_q;
	logic [IW-1:0] prow_q;
	logic          prow_ok_q;

	// Log2 unit
	logic [17:0] lv;
	logic [4:0]  lk;
	logic [47:0] lshift;
	logic [30:0] m_q;
	logic [4:0]  k_q;
	logic [15:0] frac_q;
	logic [20:0] la_q;
	logic [61:0] msq;
	logic [31:0] mt;
	logic [20:0] ldiff;
	logic [36:0] ln_prod;
	logic [20:0] ln_q;
	logic [51:0] p_prod;
	logic [31:0] inv_pot;

	// MAC and Euler step
	logic               v_s1;
	logic               v_s2;
	logic signed [48:0] prod_s2;
	logic signed [55:0] acc_q;
	logic signed [41:0] drive_q;
	logic signed [59:0] sprod_q;
	logic signed [44:0] ssum;
	logic signed [31:0] fresh;
	logic signed [31:0] fresh_q;

	// Divider and table index
	logic [32:0]                   fx;
	logic [32:0]                   mag;
	logic [31:0]                   rem_q;
	logic [19:0]                   dlo_q;
	logic [19:0]                   q_q;
	logic                          neg_q;
	logic                          big_q;
	logic [32:0]                   r2;
	logic                          r2_ge;
	logic                          q_sat;
	logic [19:0]                   u_pos;
	logic [19:0]                   u_neg;
	logic [19:0]                   u_sel;
	logic [SIGMOID_TABLE_BITS-1:0] idx_q;

	// Sigmoid table, built at elaboration
	for (genvar e = 0; e < TABLE_SIZE; e++) begin : g_rom
		localparam logic [15:0] ENTRY = sig_entry(e, SIGMOID_TABLE_BITS);
		assign sig_rom[e] = ENTRY;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neuron_count_q <= RST_NEURON_COUNT;
			iteration_q    <= RST_ITERATION_COUNT;
			step_q         <= RST_STEP_SIZE;
			gain_q         <= RST_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NEURON_COUNT:    neuron_count_q <= cfg_data[6:0];
				CFG_ITERATION_COUNT: iteration_q    <= cfg_data[15:0];
				CFG_STEP_SIZE:       step_q         <= cfg_data[16:0];
				CFG_GAIN:            gain_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	assign geff            = (gain_q == '0) ? 31'd1 : gain_q;
	assign st.neuron_count    = neuron_count_q;
	assign st.iteration_count = iteration_q;

	// Index checks and activation clamp for loads
	assign row_ok = ({26'd0, in_data.row_index} < 32'(MAX_NEURONS));
	assign col_ok = ({26'd0, in_data.col_index} < 32'(MAX_NEURONS));
	always_comb begin
		if (in_data.load_value < 0) begin
			x_sat = 16'd0;
		end else if (in_data.load_value > 32'sd65535) begin
			x_sat = 16'hFFFF;
		end else begin
			x_sat = in_data.load_value[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_act) begin
			x_q       <= x_sat;
			prow_q    <= IW'(in_data.row_index);
			prow_ok_q <= row_ok;
		end
	end

	// Weight and bias stores
	always_ff @(posedge clk) begin
		if (cmd.ld_weight && row_ok && col_ok) begin
			w_mem[WAW'(32'(in_data.row_index) * MAX_NEURONS + 32'(in_data.col_index))] <=
				in_data.load_value;
		end
		w_rd_s1 <= w_mem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_bias && row_ok) begin
			b_mem[IW'(in_data.row_index)] <= in_data.load_value;
		end
		b_rd_q <= b_mem[row_idx];
	end

	// Activation store: loads and end-of-iteration copy share the write port
	assign a_raddr = cmd.a_rd_row ? row_idx : col_idx;
	always_ff @(posedge clk) begin
		if (cmd.ld_act && row_ok) begin
			a_mem[IW'(in_data.row_index)] <= x_sat;
		end else if (cmd.copy_wr) begin
			a_mem[row_idx] <= f_rd_q;
		end
		a_rd_q <= a_mem[a_raddr];
	end

	// Fresh activations of the current iteration
	always_ff @(posedge clk) begin
		if (cmd.act_wr) begin
			f_mem[row_idx] <= sig_rom[idx_q];
		end
		f_rd_q <= f_mem[row_idx];
	end

	// Potential store: inverse activation on load, Euler result on run
	always_ff @(posedge clk) begin
		if (cmd.inv_mul2 && prow_ok_q) begin
			p_mem[prow_q] <= inv_pot;
		end else if (cmd.ssat_en) begin
			p_mem[row_idx] <= fresh;
		end
		p_rd_q <= p_mem[row_idx];
	end

	// Log2: normalize the operand so its leading one sits at bit 30
	assign lv = cmd.log_sel_b ? 18'(17'd65536 - {1'b0, x_q}) : (18'd65536 + 18'(x_q));
	always_comb begin
		lk = '0;
		for (int b = 0; b < 18; b++) begin
			if (lv[b]) begin
				lk = 5'(b);
			end
		end
	end
	assign lshift = 48'(lv) << (5'd30 - lk);

	// One fraction bit per square
	assign msq     = 62'(m_q) * 62'(m_q);
	assign mt      = msq[61:30];
	assign ldiff   = la_q - {k_q, frac_q};
	assign ln_prod = 37'(ldiff) * 37'(LN2_Q16);
	assign p_prod  = 52'(geff) * 52'(ln_q);
	assign inv_pot = (p_prod[51:48] != 4'd0) ? 32'h7FFF_FFFF : p_prod[48:17];

	always_ff @(posedge clk) begin
		if (cmd.log_init) begin
			m_q    <= lshift[30:0];
			k_q    <= lk;
			frac_q <= '0;
			if (cmd.log_sel_b) begin
				la_q <= {k_q, frac_q};
			end
		end else if (cmd.log_step) begin
			if (mt[31]) begin
				m_q <= mt[31:1];
			end else begin
				m_q <= mt[30:0];
			end
			frac_q <= {frac_q[14:0], mt[31]};
		end
		if (cmd.inv_mul1) begin
			ln_q <= ln_prod[36:16];
		end
	end

	// MAC pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac_rd;
			v_s2 <= v_s1;
		end
	end

	// Multiply weight by activation, accumulate the row
	always_ff @(posedge clk) begin
		prod_s2 <= w_rd_s1 * $signed({1'b0, a_rd_q});
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + 56'(prod_s2);
		end
	end

	// Euler step: drive, scale by step size, saturate
	assign ssum = 45'(p_rd_q) + 45'(sprod_q >>> 16);
	always_comb begin
		if (ssum > 45'sd2147483647) begin
			fresh = 32'sh7FFF_FFFF;
		end else if (ssum < -45'sd2147483648) begin
			fresh = 32'sh8000_0000;
		end else begin
			fresh = ssum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drive_en) begin
			drive_q <= 42'(acc_q >>> 16) - 42'(p_rd_q) + 42'(b_rd_q);
		end
		if (cmd.smul_en) begin
			sprod_q <= drive_q * $signed({1'b0, step_q});
		end
		if (cmd.ssat_en) begin
			fresh_q <= fresh;
		end
	end

	// Serial divide |u| * 2^16 / gain, 20 quotient bits
	assign fx    = {fresh_q[31], fresh_q};
	assign mag   = fresh_q[31] ? 33'(~fx + 33'd1) : fx;
	assign r2    = {rem_q, dlo_q[19]};
	assign r2_ge = (r2 >= {2'b00, geff});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= 32'(mag >> 4);
			dlo_q <= {mag[3:0], 16'd0};
			q_q   <= '0;
			neg_q <= fresh_q[31];
			big_q <= ({2'b00, mag} >= {geff, 4'd0});
		end else if (cmd.div_step) begin
			rem_q <= r2_ge ? 32'(r2 - {2'b00, geff}) : r2[31:0];
			dlo_q <= {dlo_q[18:0], 1'b0};
			q_q   <= {q_q[18:0], r2_ge};
		end
	end

	// Clamp to [-8, 8) and offset into the table
	assign q_sat = big_q || q_q[19];
	assign u_pos = {1'b1, (q_sat ? 19'h7FFFF : q_q[18:0])};
	assign u_neg = 20'h80000 - (q_sat ? 20'h80000 : q_q);
	assign u_sel = neg_q ? u_neg : u_pos;

	always_ff @(posedge clk) begin
		if (cmd.act_idx) begin
			idx_q <= u_sel[19 -: SIGMOID_TABLE_BITS];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data.neuron_index <= 6'(row_idx);
			out_data.activation   <= a_rd_q;
			out_data.last         <= cmd.out_last;
		end
	end

endmodule

FILE: hw/rtl/continuous_hopfield_iteration_core.sv
// ----------------------------------------------------------------------------
// continuous_hopfield_iteration_core
// Continuous Hopfield network iterator in fixed point, one item at a time.
// ----------------------------------------------------------------------------
// Weight and bias loads are written straight into their stores. An
// activation load is turned into a potential by the log2 unit, which
// squares once per fraction bit for each of its two operands. A run with
// n neurons takes I steps: in each step every row streams n weights
// through one multiply-accumulate pipeline, then the Euler update and a
// serial divider for the sigmoid argument, and each step ends by copying
// the fresh activations back with a read and a write per neuron. Results
// then leave one at a time while out_ready is high. No new item is
// accepted until the last result of a run has been taken.
// ----------------------------------------------------------------------------
module continuous_hopfield_iteration_core #(
	parameter int MAX_NEURONS        = 64,
	parameter int SIGMOID_TABLE_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  chi_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output chi_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [30:0]   cfg_data
);
	import chi_pkg::*;

	localparam int IW  = $clog2(MAX_NEURONS);
	localparam int WAW = $clog2(MAX_NEURONS * MAX_NEURONS);

	cmd_t           cmd;
	st_t            st;
	logic [IW-1:0]  row_idx;
	logic [IW-1:0]  col_idx;
	logic [WAW-1:0] w_raddr;

	// Sequencer
	chi_ctrl #(
		.MAX_NEURONS(MAX_NEURONS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_command (in_data.command),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.st         (st),
		.cmd        (cmd),
		.row_idx    (row_idx),
		.col_idx    (col_idx),
		.w_raddr    (w_raddr)
	);

	// Arithmetic and storage
	chi_dpath #(
		.MAX_NEURONS       (MAX_NEURONS),
		.SIGMOID_TABLE_BITS(SIGMOID_TABLE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.row_idx   (row_idx),
		.col_idx   (col_idx),
		.w_raddr   (w_raddr),
		.st        (st),
		.out_data  (out_data)
	);

endmodule
